// ----- design/lmf_pkg.sv -----
package lmf_pkg;

    typedef logic [7:0] t_pixel;

    // One column of the two line stores: the row two back and the row one back.
    typedef struct packed {
        t_pixel older;
        t_pixel newer;
    } t_col_pair;

endpackage

// ----- design/lmf_line_store.sv -----
module lmf_line_store #(
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_rd_en,
    input  logic [AW-1:0]     i_rd_addr,
    output lmf_pkg::t_col_pair o_rd_data,
    input  logic              i_wr_en,
    input  logic [AW-1:0]     i_wr_addr,
    input  lmf_pkg::t_col_pair i_wr_data
);
    import lmf_pkg::*;

    t_pixel    r_older_mem [DEPTH];
    t_pixel    r_newer_mem [DEPTH];
    t_col_pair r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_older_mem[i_wr_addr] <= i_wr_data.older;
            r_newer_mem[i_wr_addr] <= i_wr_data.newer;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data.older <= r_older_mem[i_rd_addr];
            r_rd_data.newer <= r_newer_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

`ifndef SYNTHESIS
    // consecutive pixels never share a column, so no read-during-write hazard
    a_no_same_col: assert property (@(posedge i_clk)
        (i_rd_en && i_wr_en) |-> (i_rd_addr != i_wr_addr))
        else $error("line store read and write hit the same column");
`endif

endmodule

// ----- design/laplacian_3x3_mirror_filter_core.sv -----
// Path: a result passes the store read, the result buffer and the output register after
//   the pixel that completes its window is transferred in, about a row after its own.
// Throughput: one pixel per cycle unless stalled; the input waits while a pixel's results
//   drain (two on the last column or last row past column 0, four at the corner).
// Reset (synchronous, active low): position, window, pipeline valids cleared; registers
//   return to width 512, height 512, gain 5. Line stores are not cleared.
module laplacian_3x3_mirror_filter_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    // configuration write port
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_index,
    input  logic [10:0]    i_cfg_wdata,
    // pixel input channel
    input  logic           i_valid,
    output logic           o_ready,
    input  lmf_pkg::t_pixel i_pixel,
    // result channel
    output logic           o_valid,
    input  logic           i_ready,
    output lmf_pkg::t_pixel o_value,
    output logic [9:0]     o_out_row,
    output logic [9:0]     o_out_col,
    output logic           o_last_of_run
);
    import lmf_pkg::*;

    localparam int WW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;   // column index
    localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1; // row index
    localparam int SWW = $clog2(MAX_WIDTH + 1);                     // holds the width
    localparam int SHW = $clog2(MAX_HEIGHT + 1);                    // holds the height

    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] REG_GAIN         = 2'd2;

    // result slots in emission order
    localparam int SLOT_A = 0;  // (r-1, c-1)
    localparam int SLOT_B = 1;  // (r-1, c)   on last column
    localparam int SLOT_C = 2;  // (r, c-1)   on last row
    localparam int SLOT_D = 3;  // (r, c)     on last row and last column

    typedef struct packed {
        logic row_ge1;   // row above exists, results can be produced
        logic col_ge1;
        logic col_one;   // left neighbor of column 0 mirrors to column 1
        logic y_zero;    // output row is the top row, up mirrors to down
        logic col_last;
        logic row_last;
    } t_pos_flags;

    typedef logic signed [10:0] t_sum;

    function automatic logic [31:0] clamp_size(logic [10:0] v, int hi);
        if (v < 11'd2) return 32'd2;
        if (32'(v) > hi) return 32'(hi);
        return 32'(v);
    endfunction

    // up + down + left + right - 4 * centre; fits 11 bits two's complement
    function automatic t_sum lap_sum(t_pixel up, t_pixel down, t_pixel left,
                                     t_pixel right, t_pixel centre);
        logic [10:0] s;
        s = 11'(up) + 11'(down) + 11'(left) + 11'(right) - 11'({centre, 2'b00});
        return $signed(s);
    endfunction

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    logic [10:0] r_frame_width;
    logic [10:0] r_frame_height;
    logic [7:0]  r_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= 11'd512;
            r_frame_height <= 11'd512;
            r_gain         <= 8'd5;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_wdata;
                REG_FRAME_HEIGHT: r_frame_height <= i_cfg_wdata;
                REG_GAIN:         r_gain         <= i_cfg_wdata[7:0];
                default: ;  // unmapped index, ignored
            endcase
        end
    end

    logic [SWW-1:0] w;
    logic [SHW-1:0] h;
    assign w = SWW'(clamp_size(r_frame_width, MAX_WIDTH));
    assign h = SHW'(clamp_size(r_frame_height, MAX_HEIGHT));

    // ------------------------------------------------------------------
    // stage 0: position tracking and line store read
    // ------------------------------------------------------------------
    logic [WW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic          accept;
    logic          s1_adv;

    logic [WW-1:0] c0;
    logic [RW-1:0] r0;
    logic [RW:0]   row_pre;
    logic [WW:0]   col_inc;
    logic [RW:0]   row_inc;
    logic          col_wrap;
    t_pos_flags    flags0;

    always_comb begin
        // a size shrunk between frames can leave the position out of range
        col_wrap = ({1'b0, r_col} >= (WW + 1)'(w));
        c0       = col_wrap ? '0 : r_col;
        row_pre  = col_wrap ? ({1'b0, r_row} + 1'b1) : {1'b0, r_row};
        r0       = (row_pre >= (RW + 1)'(h)) ? '0 : row_pre[RW-1:0];

        col_inc  = {1'b0, c0} + 1'b1;
        row_inc  = {1'b0, r0} + 1'b1;
        if (col_inc >= (WW + 1)'(w)) begin
            n_col = '0;
            n_row = (row_inc >= (RW + 1)'(h)) ? '0 : row_inc[RW-1:0];
        end else begin
            n_col = col_inc[WW-1:0];
            n_row = r0;
        end

        flags0.row_ge1  = (r0 != '0);
        flags0.col_ge1  = (c0 != '0);
        flags0.col_one  = (c0 == WW'(1));
        flags0.y_zero   = (r0 == RW'(1));
        flags0.col_last = (col_inc == (WW + 1)'(w));
        flags0.row_last = (row_inc == (RW + 1)'(h));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // ------------------------------------------------------------------
    // line stores: read at transfer in, write back when stage 1 moves on
    // ------------------------------------------------------------------
    logic          r_s1_valid;
    t_pixel        r_s1_px;
    logic [WW-1:0] r_s1_col;
    logic [RW-1:0] r_s1_row;
    t_pos_flags    r_s1_flags;
    t_col_pair     rd_pair;
    t_col_pair     wr_pair;

    assign wr_pair.older = rd_pair.newer;
    assign wr_pair.newer = r_s1_px;

    lmf_line_store #(
        .DEPTH(MAX_WIDTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (c0),
        .o_rd_data (rd_pair),
        .i_wr_en   (s1_adv),
        .i_wr_addr (r_s1_col),
        .i_wr_data (wr_pair)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_px    <= i_pixel;
            r_s1_col   <= c0;
            r_s1_row   <= r0;
            r_s1_flags <= flags0;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: window shift and Laplacian sums for up to four results
    // ------------------------------------------------------------------
    // window rows: 0 top (two rows back), 1 middle, 2 bottom (current);
    // columns: 0 is c-2, 1 is c-1, 2 is c
    t_pixel r_win [3][3];
    t_pixel wn    [3][3];
    t_sum   s1_sum [4];
    logic [3:0] s1_mask;
    logic       emit;
    t_pixel     up_a, left_a, up_b, left_c;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            wn[i][0] = r_win[i][1];
            wn[i][1] = r_win[i][2];
        end
        wn[0][2] = rd_pair.older;
        wn[1][2] = rd_pair.newer;
        wn[2][2] = r_s1_px;

        // mirrored neighbors at the top and left edges
        up_a   = r_s1_flags.y_zero  ? wn[2][1] : wn[0][1];
        left_a = r_s1_flags.col_one ? wn[1][2] : wn[1][0];
        up_b   = r_s1_flags.y_zero  ? wn[2][2] : wn[0][2];
        left_c = r_s1_flags.col_one ? wn[2][2] : wn[2][0];

        s1_sum[SLOT_A] = lap_sum(up_a, wn[2][1], left_a, wn[1][2], wn[1][1]);
        // right edge: right mirrors to left
        s1_sum[SLOT_B] = lap_sum(up_b, wn[2][2], wn[1][1], wn[1][1], wn[1][2]);
        // bottom edge: down mirrors to up
        s1_sum[SLOT_C] = lap_sum(wn[1][1], wn[1][1], left_c, wn[2][2], wn[2][1]);
        // bottom right corner
        s1_sum[SLOT_D] = lap_sum(wn[1][2], wn[1][2], wn[2][1], wn[2][1], wn[2][2]);

        emit            = r_s1_valid && r_s1_flags.row_ge1 && r_s1_flags.col_ge1;
        s1_mask[SLOT_A] = emit;
        s1_mask[SLOT_B] = emit && r_s1_flags.col_last;
        s1_mask[SLOT_C] = emit && r_s1_flags.row_last;
        s1_mask[SLOT_D] = emit && r_s1_flags.col_last && r_s1_flags.row_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[i][j] <= '0;
                end
            end
        end else if (s1_adv) begin
            r_win <= wn;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: result buffer, drained one slot per output transfer
    // ------------------------------------------------------------------
    logic [3:0] r_s2_mask;
    t_sum       r_s2_sum [4];
    logic [9:0] r_s2_row_y, r_s2_row, r_s2_col_m1, r_s2_col;

    logic       s2_pop;
    logic       s2_free;
    logic [1:0] sel;
    logic [3:0] sel_bit;
    logic [3:0] rest_mask;
    logic       sel_last;

    always_comb begin
        priority casez (r_s2_mask)
            4'b???1: sel = 2'(SLOT_A);
            4'b??10: sel = 2'(SLOT_B);
            4'b?100: sel = 2'(SLOT_C);
            default: sel = 2'(SLOT_D);
        endcase
        sel_bit   = 4'b0001 << sel;
        rest_mask = r_s2_mask & ~sel_bit;
        sel_last  = (rest_mask == 4'b0000);

        s2_pop  = (r_s2_mask != 4'b0000) && (!o_valid || i_ready);
        s2_free = (r_s2_mask == 4'b0000) || (s2_pop && sel_last);
        // a pixel without results only updates stores and window
        s1_adv  = r_s1_valid && ((s1_mask == 4'b0000) || s2_free);
    end

    assign o_ready = !r_s1_valid || s1_adv;
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_mask <= '0;
        end else if (s1_adv && (s1_mask != 4'b0000)) begin
            r_s2_mask <= s1_mask;
        end else if (s2_pop) begin
            r_s2_mask <= rest_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && (s1_mask != 4'b0000)) begin
            r_s2_sum    <= s1_sum;
            r_s2_row    <= 10'(r_s1_row);
            r_s2_row_y  <= 10'(r_s1_row) - 10'd1;
            r_s2_col    <= 10'(r_s1_col);
            r_s2_col_m1 <= 10'(r_s1_col) - 10'd1;
        end
    end

    // ------------------------------------------------------------------
    // output register: gain, clamp, position
    // ------------------------------------------------------------------
    logic signed [19:0] prod;
    t_pixel             val_sel;

    always_comb begin
        prod = r_s2_sum[sel] * $signed({1'b0, r_gain});
        if (prod < 0) begin
            val_sel = 8'd0;
        end else if (prod > 20'sd255) begin
            val_sel = 8'd255;
        end else begin
            val_sel = prod[7:0];
        end
    end

    logic   r_o_valid;
    t_pixel r_o_value;
    logic [9:0] r_o_row, r_o_col;
    logic   r_o_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s2_pop) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_pop) begin
            r_o_value <= val_sel;
            r_o_row   <= sel[1] ? r_s2_row : r_s2_row_y;  // slots C, D are the current row
            r_o_col   <= sel[0] ? r_s2_col : r_s2_col_m1; // slots B, D are the current column
            r_o_last  <= sel_last;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_value       = r_o_value;
    assign o_out_row     = r_o_row;
    assign o_out_col     = r_o_col;
    assign o_last_of_run = r_o_last;

`ifndef SYNTHESIS
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (r_s1_valid && (r_s2_mask != 4'b0000)))
        else $error("input stalled with no pending results");

    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s2_pop && !sel_last) |=> (r_s2_mask != 4'b0000))
        else $error("result run ended before its last transfer");

    // the corner goes out last: once the bottom edge result has left, nothing else is ahead
    a_corner_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_mask[SLOT_D] && !r_s2_mask[SLOT_C]) |-> (r_s2_mask[SLOT_B:SLOT_A] == 2'b00))
        else $error("corner result pending ahead of earlier results");
`endif

endmodule

// ----- dv/testbench.sv -----
module testbench;

    import lmf_pkg::*;

    // register map of the config port
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_GAIN   = 2'd2;

    localparam int unsigned FRAME_MAX   = 1024;  // both size limits of the core
    localparam int          HOLD_CYCLES = 150;   // long receiver hold-off
    localparam int          RUN_LIMIT   = 15_000_000;
    localparam int          NUM_DIRECTED = 28;
    localparam int          FILL_WIDTH  = 40;    // columns written twice before random sizes

    typedef enum int {PACE_NONE, PACE_SENDER, PACE_RECEIVER, PACE_BOTH} t_pace;
    typedef enum logic {STEP_PIXEL, STEP_REG} t_step_kind;

    // One row of the directed table. For a pixel row, data[7:0] is the pixel; a pinned
    // row forces the value field of every result the pixel causes to pinned_value.
    typedef struct packed {
        t_step_kind  kind;
        logic [1:0]  target;
        logic [10:0] data;
        logic        pinned;
        t_pixel      pinned_value;
    } t_step;

    typedef struct packed {
        t_pixel     value;
        logic [9:0] row;
        logic [9:0] col;
        logic       last;
    } t_out_pixel;

    // Directed part: mirrored 2x2 frames, clamped sizes, gain extremes, a flat frame and a
    // width shrink in the middle of a row.
    localparam t_step DIRECTED [NUM_DIRECTED] = '{
        // 0 -> 2 wide, 1 -> 2 high; first frame runs with the gain left by reset
        '{STEP_REG,   REG_WIDTH,  11'd0,   1'b0, 8'd0},
        '{STEP_REG,   REG_HEIGHT, 11'd1,   1'b0, 8'd0},
        '{STEP_PIXEL, REG_WIDTH,  11'd10,  1'b0, 8'd0},
        '{STEP_PIXEL, REG_WIDTH,  11'd20,  1'b0, 8'd0},
        '{STEP_PIXEL, REG_WIDTH,  11'd20,  1'b0, 8'd0},
        '{STEP_PIXEL, REG_WIDTH,  11'd10,  1'b0, 8'd0},
        // gain zero: all four results of the last pixel are zero
        '{STEP_REG,   REG_GAIN,   11'd0,   1'b0, 8'd0},
        '{STEP_PIXEL, REG_WIDTH,  11'd255, 1'b0, 8'd0},
        '{STEP_PIXEL, REG_WIDTH,  11'd0,   1'b0, 8'd0},
        '{STEP_PIXEL, REG_WIDTH,  11'd0,   1'b0, 8'd0},
        '{STEP_PIXEL, REG_WIDTH,  11'd255, 1'b1, 8'd0},
        // full gain on a checkerboard: saturates both ways
        '{STEP_REG,   REG_GAIN,   11'd255, 1'b0, 8'd0},
        '{STEP_PIXEL, REG_WIDTH,  11'd0,   1'b0, 8'd0},
        '{STEP_PIXEL, REG_WIDTH,  11'd255, 1'b0, 8'd0},
        '{STEP_PIXEL, REG_WIDTH,  11'd255, 1'b0, 8'd0},
        '{STEP_PIXEL, REG_WIDTH,  11'd0,   1'b0, 8'd0},
        // flat 3x2 frame: response is zero everywhere
        '{STEP_REG,   REG_WIDTH,  11'd3,   1'b0, 8'd0},
        '{STEP_PIXEL, REG_WIDTH,  11'd128, 1'b1, 8'd0},
        '{STEP_PIXEL, REG_WIDTH,  11'd128, 1'b1, 8'd0},
        '{STEP_PIXEL, REG_WIDTH,  11'd128, 1'b1, 8'd0},
        '{STEP_PIXEL, REG_WIDTH,  11'd128, 1'b1, 8'd0},
        '{STEP_PIXEL, REG_WIDTH,  11'd128, 1'b1, 8'd0},
        '{STEP_PIXEL, REG_WIDTH,  11'd128, 1'b1, 8'd0},
        // two pixels into a 3-wide row, then shrink to 2: next pixel starts row 1
        '{STEP_PIXEL, REG_WIDTH,  11'd1,   1'b0, 8'd0},
        '{STEP_PIXEL, REG_WIDTH,  11'd2,   1'b0, 8'd0},
        '{STEP_REG,   REG_WIDTH,  11'd2,   1'b0, 8'd0},
        '{STEP_PIXEL, REG_WIDTH,  11'd3,   1'b0, 8'd0},
        '{STEP_PIXEL, REG_WIDTH,  11'd4,   1'b0, 8'd0}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [10:0] i_cfg_wdata = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    t_pixel      i_pixel = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    t_pixel      o_value;
    logic [9:0]  o_out_row;
    logic [9:0]  o_out_col;
    logic        o_last_of_run;

    // filter state as the testbench sees it
    t_pixel      older_line [FRAME_MAX];
    t_pixel      newer_line [FRAME_MAX];
    t_pixel      win [3][3];  // [top, mid, bottom][col c-2, c-1, c]
    int unsigned row_pos;
    int unsigned col_pos;
    logic [10:0] frame_w;
    logic [10:0] frame_h;
    t_pixel      gain_reg;

    t_out_pixel  due_results [$];   // predicted results not yet transferred out
    int          mismatch_count = 0;
    t_pace       pace = PACE_NONE;
    bit          hold_req = 1'b0;
    logic        hold_off = 1'b0;

    laplacian_3x3_mirror_filter_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_pixel       (i_pixel),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_value       (o_value),
        .o_out_row     (o_out_row),
        .o_out_col     (o_out_col),
        .o_last_of_run (o_last_of_run)
    );

    always #6 i_clk = ~i_clk;

    function automatic int idle_pct(input t_pace p);
        return (p == PACE_BOTH) ? 18 : 86;
    endfunction

    // sizes below 2 act as 2, above the maximum as the maximum
    function automatic int unsigned eff_size(input logic [10:0] v);
        if (v < 11'd2) return 2;
        if (v > 11'(FRAME_MAX)) return FRAME_MAX;
        return 32'(v);
    endfunction

    // gain * (up + down + left + right - 4 * mid), clamped to a pixel
    function automatic t_pixel edge_response(input t_pixel up, input t_pixel down,
                                             input t_pixel lft, input t_pixel rgt,
                                             input t_pixel mid);
        int sum;
        sum = (int'(up) + int'(down) + int'(lft) + int'(rgt) - 4 * int'(mid))
              * int'(gain_reg);
        if (sum < 0) return 8'd0;
        if (sum > 255) return 8'd255;
        return t_pixel'(sum);
    endfunction

    function automatic t_out_pixel out_at(input t_pixel v, input int unsigned row,
                                          input int unsigned col);
        t_out_pixel o;
        o.value = v;
        o.row   = row[9:0];
        o.col   = col[9:0];
        o.last  = 1'b0;
        return o;
    endfunction

    function automatic t_pixel draw_pixel();
        case ($urandom_range(0, 7))
            0: return 8'd0;
            1: return 8'd255;
            default: return t_pixel'($urandom_range(0, 255));
        endcase
    endfunction

    // widths stay within the filled columns, so growing mid-frame reads written entries
    function automatic logic [10:0] draw_width();
        case ($urandom_range(0, 15))
            0: return 11'd0;
            1: return 11'd1;
            2: return 11'(FILL_WIDTH);
            3: return 11'd25;
            default: return 11'($urandom_range(2, 12));
        endcase
    endfunction

    function automatic logic [10:0] draw_height();
        case ($urandom_range(0, 15))
            0: return 11'd0;
            1: return 11'd1;
            2: return 11'd2047;
            default: return 11'($urandom_range(2, 6));
        endcase
    endfunction

    function automatic logic [10:0] draw_gain();
        case ($urandom_range(0, 7))
            0: return 11'd0;
            1: return 11'd1;
            2: return 11'd255;
            3: return 11'd5;
            default: return 11'($urandom_range(0, 255));
        endcase
    endfunction

    // Advance the filter by one accepted pixel and queue the results it causes: row r-1 is
    // finished while row r comes in, and the last row also finishes itself.
    task automatic filter_pixel(input t_pixel px, input logic pinned, input t_pixel pin_v);
        int unsigned w, h, r, c, y;
        int          i;
        t_pixel      up, lft;
        t_out_pixel  found [$];
        begin
            w = eff_size(frame_w);
            h = eff_size(frame_h);
            // a size change may leave the position beyond the frame
            if (col_pos >= w) begin
                col_pos = 0;
                row_pos++;
            end
            if (row_pos >= h) row_pos = 0;
            r = row_pos;
            c = col_pos;

            for (i = 0; i < 3; i++) begin
                win[i][0] = win[i][1];
                win[i][1] = win[i][2];
            end
            win[0][2] = older_line[c];
            win[1][2] = newer_line[c];
            win[2][2] = px;
            older_line[c] = newer_line[c];
            newer_line[c] = px;

            if (r >= 1 && c >= 1) begin
                y = r - 1;
                // top row mirrors onto the row below; column 0 mirrors onto column 1
                up  = (y == 0) ? win[2][1] : win[0][1];
                lft = (c == 1) ? win[1][2] : win[1][0];
                found.push_back(out_at(edge_response(up, win[2][1], lft, win[1][2],
                                                     win[1][1]), y, c - 1));
                if (c == w - 1) begin
                    // right edge mirrors onto column W-2
                    up = (y == 0) ? win[2][2] : win[0][2];
                    found.push_back(out_at(edge_response(up, win[2][2], win[1][1],
                                                         win[1][1], win[1][2]), y, c));
                end
                if (r == h - 1) begin
                    // bottom row mirrors onto row H-2
                    lft = (c == 1) ? win[2][2] : win[2][0];
                    found.push_back(out_at(edge_response(win[1][1], win[1][1], lft,
                                                         win[2][2], win[2][1]), r, c - 1));
                    if (c == w - 1)
                        found.push_back(out_at(edge_response(win[1][2], win[1][2],
                                                             win[2][1], win[2][1],
                                                             win[2][2]), r, c));
                end
            end
            if (found.size() > 0) found[found.size() - 1].last = 1'b1;
            foreach (found[k]) begin
                if (pinned) found[k].value = pin_v;
                due_results.push_back(found[k]);
            end

            col_pos = c + 1;
            if (col_pos >= w) begin
                col_pos = 0;
                row_pos = r + 1;
                if (row_pos >= h) row_pos = 0;
            end
        end
    endtask

    // Offer one pixel until it is transferred; valid stays up into the next call unless
    // the sender takes a gap.
    task automatic push_pixel(input t_pixel px, input logic pinned, input t_pixel pin_v);
        begin
            i_cfg_we <= 1'b0;
            i_valid  <= 1'b1;
            i_pixel  <= px;
            do @(posedge i_clk); while (!o_ready);
            filter_pixel(px, pinned, pin_v);
            if ((pace == PACE_SENDER || pace == PACE_BOTH)
                    && $urandom_range(0, 99) < idle_pct(pace)) begin
                i_valid <= 1'b0;
                do @(posedge i_clk); while ($urandom_range(0, 99) < idle_pct(pace));
            end
        end
    endtask

    // Stop offering, wait for every predicted result, then give pixels that cause no
    // result (store writes in flight) about a row's time to land.
    task automatic settle();
        begin
            i_valid  <= 1'b0;
            i_cfg_we <= 1'b0;
            while (due_results.size() != 0) @(posedge i_clk);
            repeat (eff_size(frame_w) + 8) @(posedge i_clk);
        end
    endtask

    // Write enable stays up after the write; the next pixel or settle lowers it.
    task automatic write_reg(input logic [1:0] target, input logic [10:0] data);
        begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= target;
            i_cfg_wdata <= data;
            @(posedge i_clk);
            case (target)
                REG_WIDTH:  frame_w  = data;
                REG_HEIGHT: frame_h  = data;
                REG_GAIN:   gain_reg = data[7:0];
                default: ;
            endcase
        end
    endtask

    // Result side: check every transfer against the oldest prediction, then pick the
    // next ready. Values read here are the ones present at this edge.
    always @(posedge i_clk) begin : result_side
        t_out_pixel want;
        if (i_rst_n && o_valid && i_ready) begin
            if (due_results.size() == 0) begin
                if (mismatch_count < 10)
                    $display("unexpected result: value %0d row %0d col %0d last %0b",
                             o_value, o_out_row, o_out_col, o_last_of_run);
                mismatch_count++;
            end else begin
                want = due_results.pop_front();
                if (o_value !== want.value || o_out_row !== want.row
                        || o_out_col !== want.col || o_last_of_run !== want.last) begin
                    if (mismatch_count < 10)
                        $display({"result mismatch: want value %0d row %0d col %0d ",
                                  "last %0b, got value %0d row %0d col %0d last %0b"},
                                 want.value, want.row, want.col, want.last,
                                 o_value, o_out_row, o_out_col, o_last_of_run);
                    mismatch_count++;
                end
            end
        end
        if (hold_off)
            i_ready <= 1'b0;
        else if (pace == PACE_RECEIVER || pace == PACE_BOTH)
            i_ready <= ($urandom_range(0, 99) >= idle_pct(pace));
        else
            i_ready <= 1'b1;
    end

    // Long receiver hold-off, counted here, while the sender keeps offering pixels.
    initial begin : receiver_hold
        wait (hold_req);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin : run_limit
        #(RUN_LIMIT);
        $display("testbench: errors");
        $finish;
    end

    initial begin : stimulus
        t_step st;
        bit    prev_reg;
        int    made;
        int    phase;
        int    n;

        // state after reset; stores are never read before being written
        foreach (older_line[k]) older_line[k] = '0;
        foreach (newer_line[k]) newer_line[k] = '0;
        foreach (win[a, b]) win[a][b] = '0;
        row_pos  = 0;
        col_pos  = 0;
        frame_w  = 11'd512;
        frame_h  = 11'd512;
        gain_reg = 8'd5;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table; registers only change with nothing in flight
        pace = PACE_BOTH;
        prev_reg = 1'b1;
        made = 0;
        for (int i = 0; i < NUM_DIRECTED; i++) begin
            st = DIRECTED[i];
            if (st.kind == STEP_REG) begin
                if (!prev_reg) settle();
                write_reg(st.target, st.data);
                prev_reg = 1'b1;
            end else begin
                push_pixel(st.data[7:0], st.pinned, st.pinned_value);
                made++;
                prev_reg = 1'b0;
            end
        end

        // full two-row frame: writes every column used later twice, so later width
        // changes never expose an unwritten entry
        pace = PACE_SENDER;
        settle();
        write_reg(REG_WIDTH, 11'(FILL_WIDTH));
        write_reg(REG_HEIGHT, 11'd2);
        write_reg(REG_GAIN, 11'd3);
        repeat (2 * FILL_WIDTH) push_pixel(draw_pixel(), 1'b0, 8'd0);
        made += 2 * FILL_WIDTH;

        // oversized frame (2047 clamps to the maximum): part of the top row only
        settle();
        write_reg(REG_WIDTH, 11'd2047);
        write_reg(REG_HEIGHT, 11'd2047);
        repeat (30) push_pixel(draw_pixel(), 1'b0, 8'd0);
        made += 30;

        // shrink to two columns: the position moves to row 1 and rows keep counting
        pace = PACE_RECEIVER;
        settle();
        write_reg(REG_WIDTH, 11'd2);
        write_reg(REG_GAIN, 11'd1);
        repeat (80) push_pixel(draw_pixel(), 1'b0, 8'd0);
        made += 80;

        // back-pressure: receiver holds off while the sender streams
        pace = PACE_NONE;
        settle();
        write_reg(REG_WIDTH, 11'd6);
        write_reg(REG_HEIGHT, 11'd5);
        write_reg(REG_GAIN, 11'd2);
        hold_req = 1'b1;
        repeat (120) push_pixel(draw_pixel(), 1'b0, 8'd0);
        made += 120;

        // random phases; a phase may end mid-row, so new sizes often land mid-frame
        phase = 0;
        while (made < 370) begin
            pace = t_pace'(phase % 4);
            if ($urandom_range(0, 9) < 7) begin
                settle();
                if ($urandom_range(0, 1)) write_reg(REG_WIDTH, draw_width());
                if ($urandom_range(0, 1)) write_reg(REG_HEIGHT, draw_height());
                if ($urandom_range(0, 1)) write_reg(REG_GAIN, draw_gain());
            end
            n = $urandom_range(15, 50);
            repeat (n) push_pixel(draw_pixel(), 1'b0, 8'd0);
            made += n;
            phase++;
        end

        settle();
        if (mismatch_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

// ----- files.f -----
design/lmf_pkg.sv
design/lmf_line_store.sv
design/laplacian_3x3_mirror_filter_core.sv
dv/testbench.sv
